/* src/p2qe_pkg.sv */
// Package for the P-square quantile estimator core.
// Holds the default parameter values, sequencer state type and phase codes.
// No dependencies.
package p2qe_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 32;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int COUNT_WIDTH_DEF   = 32;

    // Fixed widths of the configuration register and of the estimate field.
    localparam int QL_W  = 16;
    localparam int EST_W = 48;
    localparam logic [QL_W-1:0] QL_RESET = 16'd32768;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SORT,
        S_MCHK,
        S_LOAD,
        S_MULA,
        S_MULB,
        S_DSTART,
        S_DWAIT,
        S_PCHK,
        S_OUT
    } t_state;

    // Which scaled term the shared multiply and divide path is working on.
    typedef enum logic [1:0] {
        PH_T1,
        PH_T2,
        PH_LIN
    } t_phase;

    typedef struct packed {
        logic start;
        logic done;
    } t_div_ctl;

endpackage

/* src/p2qe_divider.sv */
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
// Uses p2qe_pkg for its handshake struct.
module p2qe_divider #(
    parameter int W = 82
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [W-1:0]        i_num,
    input  logic [W-1:0]        i_den,
    output p2qe_pkg::t_div_ctl  o_ctl,
    output logic [W-1:0]        o_quot
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W:0]    r_rem;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_den;
    logic [W:0]    w_trial;
    logic          w_ge;

    assign w_trial = {r_rem[W-1:0], r_quo[W-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
            r_quo <= {r_quo[W-2:0], w_ge};
        end
    end

    assign o_ctl.start = i_start;
    assign o_ctl.done  = r_done;
    assign o_quot      = r_quo;

endmodule

/* src/p2_quantile_estimator_core.sv */
// Top level of the P-square streaming quantile estimator.
// Depends on p2qe_pkg and p2qe_divider.
//
// Channel   Dir  Handshake                Payload
// s_axis    in   i_s_tvalid/o_s_tready    tdata: sample; tlast: last
// m_axis    out  o_m_tvalid/i_m_tready    tdata: estimate; tuser: ready_res, overflow
// cfg       in   i_cfg_valid/o_cfg_ready  i_cfg_data: quantile_level
//
// A sample that fills one of the first five markers goes straight to output; the fifth
// also sorts the heights. A later sample is checked against each inner marker in turn,
// and each marker that moves takes two or three scaled terms (each made of two
// multiplies by shift and add and one bit-serial division).
// Reset is synchronous and clears the control state only.
// A stalled output holds one result while the next sample is already being worked on.
module p2_quantile_estimator_core #(
    parameter int SAMPLE_WIDTH  = p2qe_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = p2qe_pkg::FRACTION_BITS_DEF,
    parameter int COUNT_WIDTH   = p2qe_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // [SAMPLE_WIDTH-1:0] sample, zero fill above
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] i_s_tdata,
    input  logic                         i_s_tlast,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // [47:0] estimate
    output logic [p2qe_pkg::EST_W-1:0]   o_m_tdata,
    // [0] ready_res, [1] overflow
    output logic [1:0]                   o_m_tuser,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [p2qe_pkg::QL_W-1:0]    i_cfg_data
);

    localparam int SW   = SAMPLE_WIDTH;
    localparam int FB   = FRACTION_BITS;
    localparam int NW   = COUNT_WIDTH;
    localparam int HW   = SW + FB;
    localparam int DW   = NW + FB + 1;
    localparam int CMPW = DW + 1;
    localparam int MW   = (HW + 1 > NW) ? HW + 1 : NW;
    localparam int PW   = MW + NW + 1;
    localparam int QW   = (PW > 62) ? PW : 62;
    localparam int TW   = QW + 1;
    localparam int EW   = TW + 2;
    localparam int CNTW = $clog2(NW + 1);
    localparam logic [QW-1:0] LIMIT = QW'(1) << 61;
    localparam logic [DW-1:0] ONE   = DW'(1) << FB;

    p2qe_pkg::t_state  r_state, n_state;
    p2qe_pkg::t_phase  r_phase;
    p2qe_pkg::t_div_ctl w_div;

    logic [2:0]              r_fill;
    logic                    r_ovf;
    logic                    r_ovalid;
    logic [p2qe_pkg::QL_W-1:0] r_ql;
    logic [2:0]              r_mi;
    logic [CNTW-1:0]         r_cnt;
    logic                    r_last;

    logic signed [HW-1:0]    r_h [5];
    logic [NW-1:0]           r_pos [5];
    logic [DW-1:0]           r_d [5];

    logic                    r_up;
    logic [NW-1:0]           r_lo, r_hi, r_n;
    logic signed [HW-1:0]    r_qm, r_qi, r_qn;
    logic                    r_neg;
    logic [MW-1:0]           r_mcand;
    logic [NW:0]             r_mplier;
    logic [PW-1:0]           r_acc, r_num, r_den;
    logic signed [TW-1:0]    r_t1, r_t2;
    logic [p2qe_pkg::EST_W-1:0] r_odata;
    logic [1:0]              r_ouser;

    logic                    w_accept, w_out_load, w_div_start, w_cap;
    logic [FB+15:0]          w_pwide;
    logic [FB-1:0]           w_p;
    logic signed [HW-1:0]    w_x;
    logic [2:0]              w_k;
    logic [NW-1:0]           w_n, w_pm, w_pn, w_lo, w_hi;
    logic [DW-1:0]           w_np;
    logic signed [HW-1:0]    w_qm, w_qi, w_qn;
    logic                    w_up, w_dn, w_move;
    logic signed [HW:0]      w_xs;
    logic [NW:0]             w_as, w_cs;
    logic [NW-1:0]           w_bs;
    logic [MW-1:0]           w_mag;
    logic [PW-1:0]           w_acc_nx;
    logic [PW-1:0]           w_quot, w_q;
    logic [QW-1:0]           w_qlim;
    logic signed [TW-1:0]    w_t;
    logic signed [EW-1:0]    w_sum, w_qp, w_qlin;
    logic                    w_pok;
    logic                    w_mul_end;

    p2qe_divider #(.W(PW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_ctl   (w_div),
        .o_quot  (w_quot)
    );

    assign w_accept  = i_s_tvalid && o_s_tready;
    assign w_pwide   = {r_ql, FB'(0)};
    assign w_p       = w_pwide[FB+15:16];
    assign w_x       = {i_s_tdata[SW-1:0], FB'(0)};
    assign w_cap     = (r_pos[4] == {NW{1'b1}});
    assign w_mul_end = (r_cnt == CNTW'(NW));

    // Cell search for the incoming sample.
    always_comb begin
        priority if (w_x < r_h[0])  w_k = 3'd0;
        else if (w_x >= r_h[4])     w_k = 3'd3;
        else if (w_x >= r_h[3])     w_k = 3'd3;
        else if (w_x >= r_h[2])     w_k = 3'd2;
        else if (w_x >= r_h[1])     w_k = 3'd1;
        else                        w_k = 3'd0;
    end

    // Neighbours of the inner marker under work.
    always_comb begin
        unique case (r_mi)
            3'd1: begin
                w_n = r_pos[1]; w_pm = r_pos[0]; w_pn = r_pos[2]; w_np = r_d[1];
                w_qm = r_h[0];  w_qi = r_h[1];   w_qn = r_h[2];
            end
            3'd2: begin
                w_n = r_pos[2]; w_pm = r_pos[1]; w_pn = r_pos[3]; w_np = r_d[2];
                w_qm = r_h[1];  w_qi = r_h[2];   w_qn = r_h[3];
            end
            default: begin
                w_n = r_pos[3]; w_pm = r_pos[2]; w_pn = r_pos[4]; w_np = r_d[3];
                w_qm = r_h[2];  w_qi = r_h[3];   w_qn = r_h[4];
            end
        endcase
    end

    assign w_lo   = w_n - w_pm;
    assign w_hi   = w_pn - w_n;
    assign w_up   = (CMPW'(w_np) >= ((CMPW'(w_n) + CMPW'(1)) << FB)) && (w_hi > NW'(1));
    assign w_dn   = ((CMPW'(w_np) + CMPW'(ONE)) <= (CMPW'(w_n) << FB)) && (w_lo > NW'(1));
    assign w_move = w_up || w_dn;

    // Operands of the scaled term x * a / (b * c) for the current phase.
    always_comb begin
        unique case (r_phase)
            p2qe_pkg::PH_T1: begin
                w_xs = (HW+1)'(r_qn) - (HW+1)'(r_qi);
                w_as = r_up ? ((NW+1)'(r_lo) + (NW+1)'(1)) : ((NW+1)'(r_lo) - (NW+1)'(1));
                w_bs = r_hi;
                w_cs = (NW+1)'(r_lo) + (NW+1)'(r_hi);
            end
            p2qe_pkg::PH_T2: begin
                w_xs = (HW+1)'(r_qi) - (HW+1)'(r_qm);
                w_as = r_up ? ((NW+1)'(r_hi) - (NW+1)'(1)) : ((NW+1)'(r_hi) + (NW+1)'(1));
                w_bs = r_lo;
                w_cs = (NW+1)'(r_lo) + (NW+1)'(r_hi);
            end
            default: begin
                w_xs = r_up ? ((HW+1)'(r_qn) - (HW+1)'(r_qi))
                            : ((HW+1)'(r_qm) - (HW+1)'(r_qi));
                w_as = (NW+1)'(1);
                w_bs = r_up ? r_hi : r_lo;
                w_cs = (NW+1)'(1);
            end
        endcase
    end

    assign w_mag    = MW'(w_xs[HW] ? -w_xs : w_xs);
    assign w_acc_nx = {r_acc[PW-2:0], 1'b0} + (r_mplier[NW] ? PW'(r_mcand) : PW'(0));

    assign w_q    = (r_den == '0) ? '0 : w_quot;
    assign w_qlim = (QW'(w_q) > LIMIT) ? LIMIT : QW'(w_q);
    assign w_t    = r_neg ? -$signed({1'b0, w_qlim}) : $signed({1'b0, w_qlim});
    assign w_qlin = EW'(r_qi) + EW'(w_t);
    assign w_sum  = EW'(r_t1) + EW'(r_t2);
    assign w_qp   = r_up ? (EW'(r_qi) + w_sum) : (EW'(r_qi) - w_sum);
    assign w_pok  = (EW'(r_qm) < w_qp) && (w_qp < EW'(r_qn));

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            p2qe_pkg::S_IDLE: begin
                if (w_accept) begin
                    priority if (r_fill < 3'd4)   n_state = p2qe_pkg::S_OUT;
                    else if (r_fill == 3'd4)      n_state = p2qe_pkg::S_SORT;
                    else if (r_ovf || w_cap)      n_state = p2qe_pkg::S_OUT;
                    else                          n_state = p2qe_pkg::S_MCHK;
                end
            end
            p2qe_pkg::S_SORT:
                if (r_cnt == CNTW'(4)) n_state = p2qe_pkg::S_OUT;
            p2qe_pkg::S_MCHK: begin
                priority if (w_move)      n_state = p2qe_pkg::S_LOAD;
                else if (r_mi == 3'd3)    n_state = p2qe_pkg::S_OUT;
                else                      n_state = p2qe_pkg::S_MCHK;
            end
            p2qe_pkg::S_LOAD:   n_state = p2qe_pkg::S_MULA;
            p2qe_pkg::S_MULA:   if (w_mul_end) n_state = p2qe_pkg::S_MULB;
            p2qe_pkg::S_MULB:   if (w_mul_end) n_state = p2qe_pkg::S_DSTART;
            p2qe_pkg::S_DSTART: n_state = p2qe_pkg::S_DWAIT;
            p2qe_pkg::S_DWAIT: begin
                if (w_div.done) begin
                    unique case (r_phase)
                        p2qe_pkg::PH_T1: n_state = p2qe_pkg::S_LOAD;
                        p2qe_pkg::PH_T2: n_state = p2qe_pkg::S_PCHK;
                        default: n_state = (r_mi == 3'd3) ? p2qe_pkg::S_OUT : p2qe_pkg::S_MCHK;
                    endcase
                end
            end
            p2qe_pkg::S_PCHK: begin
                priority if (!w_pok)      n_state = p2qe_pkg::S_LOAD;
                else if (r_mi == 3'd3)    n_state = p2qe_pkg::S_OUT;
                else                      n_state = p2qe_pkg::S_MCHK;
            end
            p2qe_pkg::S_OUT:
                if (w_out_load) n_state = p2qe_pkg::S_IDLE;
            default: n_state = p2qe_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        o_s_tready  = (r_state == p2qe_pkg::S_IDLE);
        w_div_start = (r_state == p2qe_pkg::S_DSTART);
        w_out_load  = (r_state == p2qe_pkg::S_OUT) && (!r_ovalid || i_m_tready);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= p2qe_pkg::S_IDLE;
            r_fill   <= '0;
            r_ovf    <= 1'b0;
            r_ovalid <= 1'b0;
            r_ql     <= p2qe_pkg::QL_RESET;
            r_mi     <= 3'd1;
            r_phase  <= p2qe_pkg::PH_T1;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_ql <= i_cfg_data;
            if (w_out_load) r_ovalid <= 1'b1;
            else if (i_m_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                p2qe_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_mi  <= 3'd1;
                        r_cnt <= '0;
                        if (r_fill < 3'd5) r_fill <= r_fill + 3'd1;
                        else if (!r_ovf && w_cap) r_ovf <= 1'b1;
                    end
                end
                p2qe_pkg::S_SORT: r_cnt <= r_cnt + CNTW'(1);
                p2qe_pkg::S_MCHK: begin
                    if (w_move) r_phase <= p2qe_pkg::PH_T1;
                    else r_mi <= r_mi + 3'd1;
                end
                p2qe_pkg::S_LOAD: r_cnt <= '0;
                p2qe_pkg::S_MULA,
                p2qe_pkg::S_MULB: r_cnt <= w_mul_end ? '0 : r_cnt + CNTW'(1);
                p2qe_pkg::S_DWAIT: begin
                    if (w_div.done) begin
                        unique case (r_phase)
                            p2qe_pkg::PH_T1: r_phase <= p2qe_pkg::PH_T2;
                            p2qe_pkg::PH_T2: r_phase <= p2qe_pkg::PH_T2;
                            default:         r_mi <= r_mi + 3'd1;
                        endcase
                    end
                end
                p2qe_pkg::S_PCHK: begin
                    if (w_pok) r_mi <= r_mi + 3'd1;
                    else r_phase <= p2qe_pkg::PH_LIN;
                end
                p2qe_pkg::S_OUT: begin
                    if (w_out_load && r_last) begin
                        r_fill <= '0;
                        r_ovf  <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Marker storage and the shared multiply path.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            p2qe_pkg::S_IDLE: begin
                if (w_accept) begin
                    r_last <= i_s_tlast;
                    if (r_fill < 3'd5) begin
                        r_h[r_fill] <= w_x;
                    end else if (!r_ovf && !w_cap) begin
                        if (w_x < r_h[0]) r_h[0] <= w_x;
                        else if (w_x > r_h[4]) r_h[4] <= w_x;
                        for (int j = 1; j < 5; j++)
                            if (3'(j) > w_k) r_pos[j] <= r_pos[j] + NW'(1);
                        r_d[1] <= r_d[1] + DW'(w_p >> 1);
                        r_d[2] <= r_d[2] + DW'(w_p);
                        r_d[3] <= r_d[3] + ((ONE + DW'(w_p)) >> 1);
                        r_d[4] <= r_d[4] + ONE;
                    end
                end
            end
            p2qe_pkg::S_SORT: begin
                // Odd-even transposition: five passes sort five heights.
                if (!r_cnt[0]) begin
                    if (r_h[0] > r_h[1]) begin r_h[0] <= r_h[1]; r_h[1] <= r_h[0]; end
                    if (r_h[2] > r_h[3]) begin r_h[2] <= r_h[3]; r_h[3] <= r_h[2]; end
                end else begin
                    if (r_h[1] > r_h[2]) begin r_h[1] <= r_h[2]; r_h[2] <= r_h[1]; end
                    if (r_h[3] > r_h[4]) begin r_h[3] <= r_h[4]; r_h[4] <= r_h[3]; end
                end
                for (int j = 0; j < 5; j++) r_pos[j] <= NW'(j);
                r_d[0] <= '0;
                r_d[1] <= DW'(w_p) << 1;
                r_d[2] <= DW'(w_p) << 2;
                r_d[3] <= (ONE << 1) + (DW'(w_p) << 1);
                r_d[4] <= ONE << 2;
            end
            p2qe_pkg::S_MCHK: begin
                r_up <= w_up;
                r_lo <= w_lo;
                r_hi <= w_hi;
                r_n  <= w_n;
                r_qm <= w_qm;
                r_qi <= w_qi;
                r_qn <= w_qn;
            end
            p2qe_pkg::S_LOAD: begin
                r_neg    <= w_xs[HW];
                r_mcand  <= w_mag;
                r_mplier <= w_as;
                r_acc    <= '0;
            end
            p2qe_pkg::S_MULA: begin
                if (w_mul_end) begin
                    r_num    <= w_acc_nx;
                    r_mcand  <= MW'(w_bs);
                    r_mplier <= w_cs;
                    r_acc    <= '0;
                end else begin
                    r_acc    <= w_acc_nx;
                    r_mplier <= {r_mplier[NW-1:0], 1'b0};
                end
            end
            p2qe_pkg::S_MULB: begin
                r_acc    <= w_acc_nx;
                r_mplier <= {r_mplier[NW-1:0], 1'b0};
                if (w_mul_end) r_den <= w_acc_nx;
            end
            p2qe_pkg::S_DWAIT: begin
                if (w_div.done) begin
                    unique case (r_phase)
                        p2qe_pkg::PH_T1: r_t1 <= w_t;
                        p2qe_pkg::PH_T2: r_t2 <= w_t;
                        default: begin
                            r_h[r_mi]   <= HW'(w_qlin);
                            r_pos[r_mi] <= r_up ? r_n + NW'(1) : r_n - NW'(1);
                        end
                    endcase
                end
            end
            p2qe_pkg::S_PCHK: begin
                if (w_pok) begin
                    r_h[r_mi]   <= HW'(w_qp);
                    r_pos[r_mi] <= r_up ? r_n + NW'(1) : r_n - NW'(1);
                end
            end
            p2qe_pkg::S_OUT: begin
                if (w_out_load) begin
                    r_odata <= (r_fill == 3'd5) ? p2qe_pkg::EST_W'(r_h[2]) : '0;
                    r_ouser <= {r_ovf, r_fill == 3'd5};
                end
            end
            default: ;
        endcase
    end

    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tuser   = r_ouser;
    assign o_cfg_ready = 1'b1;

    a_pos_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == p2qe_pkg::S_IDLE && r_fill == 3'd5) |->
        (r_pos[0] < r_pos[1] && r_pos[1] < r_pos[2] && r_pos[2] < r_pos[3]
         && r_pos[3] < r_pos[4]))
        else $error("marker positions not strictly increasing");

    a_height_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == p2qe_pkg::S_IDLE && r_fill == 3'd5) |->
        (r_h[0] <= r_h[1] && r_h[1] <= r_h[2] && r_h[2] <= r_h[3] && r_h[3] <= r_h[4]))
        else $error("marker heights out of order");

    a_fill_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_fill < 3'd4) |=> (r_state == p2qe_pkg::S_OUT))
        else $error("filling transaction did not go straight to output");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> (r_state == p2qe_pkg::S_DWAIT && !w_div.done))
        else $error("divider finished too early");

endmodule

/* dv/p2_quantile_estimator_core_test.sv */
// Self-checking testbench for the P-square quantile estimator core.
// Drives sample streams and level settings and checks every estimate against
// an in-bench model of the marker updates. Depends on p2qe_pkg and the core.
`timescale 1ns / 100ps

module p2_quantile_estimator_core_test;

    localparam longint unsigned ONE_FX    = 64'd65536;
    localparam longint unsigned COUNT_CAP = 64'hFFFF_FFFF;
    localparam logic [127:0]    TERM_CAP  = 128'd1 << 61;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        logic [31:0] sample;
        logic        last;
    } t_sample_item;

    typedef struct packed {
        logic [p2qe_pkg::EST_W-1:0] estimate;
        logic [1:0]                 flags;
    } t_estimate;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [31:0] i_s_tdata = '0;
    logic i_s_tlast = 1'b0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [p2qe_pkg::EST_W-1:0] o_m_tdata;
    logic [1:0] o_m_tuser;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [p2qe_pkg::QL_W-1:0] i_cfg_data = '0;

    p2_quantile_estimator_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Model state of the estimator.
    logic [p2qe_pkg::QL_W-1:0] level_m;
    longint           heights[5];
    longint unsigned  positions[5];
    longint unsigned  desired[5];
    int               filled;
    bit               saturated;

    t_sample_item pending_samples[$];
    t_estimate    expected_estimates[$];
    int  error_count = 0;
    int  samples_taken = 0;
    bit  steady_flow = 1'b0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    int  quiet_cycles = 0;

    function automatic void reset_desired();
        desired[0] = 0;
        desired[1] = 2 * level_m;
        desired[2] = 4 * level_m;
        desired[3] = 2 * ONE_FX + 2 * level_m;
        desired[4] = 4 * ONE_FX;
    endfunction

    function automatic void restart_set();
        for (int i = 0; i < 5; i++) begin
            heights[i] = 0;
            positions[i] = i;
        end
        reset_desired();
        filled = 0;
        saturated = 1'b0;
    endfunction

    // x * a / (b * c), truncated toward zero, magnitude capped at 2^61.
    function automatic longint scaled_term(longint x, longint unsigned a,
                                           longint unsigned b, longint unsigned c);
        logic [127:0] mag, quo;
        if (b == 0 || c == 0) return 0;
        mag = (x < 0) ? 128'(64'(-x)) : 128'(64'(x));
        quo = (mag * 128'(a)) / (128'(b) * 128'(c));
        if (quo > TERM_CAP) quo = TERM_CAP;
        return (x < 0) ? -longint'(quo[63:0]) : longint'(quo[63:0]);
    endfunction

    function automatic void adjust_marker(int i);
        longint unsigned n, lo_gap, hi_gap;
        longint qm, qi, qn, t1, t2, qp;
        bit up;
        n = positions[i];
        lo_gap = n - positions[i-1];
        hi_gap = positions[i+1] - n;
        qm = heights[i-1];
        qi = heights[i];
        qn = heights[i+1];
        if (desired[i] >= (n + 1) * ONE_FX && hi_gap > 1) up = 1'b1;
        else if (desired[i] + ONE_FX <= n * ONE_FX && lo_gap > 1) up = 1'b0;
        else return;
        t1 = scaled_term(qn - qi, up ? lo_gap + 1 : lo_gap - 1, hi_gap, lo_gap + hi_gap);
        t2 = scaled_term(qi - qm, up ? hi_gap - 1 : hi_gap + 1, lo_gap, lo_gap + hi_gap);
        qp = up ? qi + (t1 + t2) : qi - (t1 + t2);
        // The parabola must stay strictly between the neighbors, else go linear.
        if (!(qm < qp && qp < qn)) begin
            if (up) qp = qi + scaled_term(qn - qi, 1, hi_gap, 1);
            else qp = qi + scaled_term(qm - qi, 1, lo_gap, 1);
        end
        heights[i] = qp;
        positions[i] = up ? n + 1 : n - 1;
    endfunction

    function automatic void absorb_sample(longint x);
        int k;
        if (x < heights[0]) begin
            heights[0] = x;
            k = 0;
        end else if (x >= heights[4]) begin
            if (x > heights[4]) heights[4] = x;
            k = 3;
        end else begin
            k = 0;
            for (int i = 1; i < 4; i++)
                if (x >= heights[i]) k = i;
        end
        for (int i = k + 1; i < 5; i++) positions[i]++;
        desired[1] += level_m >> 1;
        desired[2] += level_m;
        desired[3] += (ONE_FX + level_m) >> 1;
        desired[4] += ONE_FX;
        for (int i = 1; i < 4; i++) adjust_marker(i);
    endfunction

    function automatic t_estimate predict_estimate(t_sample_item it);
        t_estimate r;
        longint x, t;
        x = longint'($signed(it.sample)) * 65536;
        if (filled < 5) begin
            heights[filled] = x;
            filled++;
            if (filled == 5) begin
                for (int i = 1; i < 5; i++)
                    for (int j = i; j > 0 && heights[j-1] > heights[j]; j--) begin
                        t = heights[j];
                        heights[j] = heights[j-1];
                        heights[j-1] = t;
                    end
                for (int i = 0; i < 5; i++) positions[i] = i;
                reset_desired();
            end
        end else if (!saturated) begin
            if (positions[4] >= COUNT_CAP) saturated = 1'b1;
            else absorb_sample(x);
        end
        r.estimate = (filled >= 5) ? heights[2][p2qe_pkg::EST_W-1:0] : '0;
        r.flags = {saturated, filled >= 5};
        if (it.last) restart_set();
        return r;
    endfunction

    // Sample sender; an offered transaction is held until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                expected_estimates.push_back(predict_estimate(pending_samples.pop_front()));
                samples_taken++;
            end
            if (pending_samples.size() > 0 &&
                ((i_s_tvalid && !o_s_tready) || steady_flow || $urandom_range(99) >= 35)) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= pending_samples[0].sample;
                i_s_tlast  <= pending_samples[0].last;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Estimate receiver and checker.
    always @(posedge i_clk) begin
        t_estimate got, want;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.estimate = o_m_tdata;
                got.flags = o_m_tuser;
                if (expected_estimates.size() == 0) begin
                    $display("%0t: unexpected estimate %h flags %b", $time,
                             got.estimate, got.flags);
                    error_count++;
                end else begin
                    want = expected_estimates.pop_front();
                    if (got.estimate !== want.estimate) begin
                        $display("%0t: estimate expected %h actual %h", $time,
                                 want.estimate, got.estimate);
                        error_count++;
                    end
                    if (got.flags !== want.flags) begin
                        $display("%0t: flags expected %b actual %b", $time,
                                 want.flags, got.flags);
                        error_count++;
                    end
                end
            end
            // One long hold-off while the sender keeps offering samples.
            if (!hold_done && samples_taken >= 300) begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                i_m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= steady_flow || $urandom_range(99) >= 35;
            end
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic drain();
        wait (pending_samples.size() == 0 && !i_s_tvalid && expected_estimates.size() == 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_level(logic [p2qe_pkg::QL_W-1:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        level_m = value;
    endtask

    task automatic queue_sample(logic [31:0] s, logic l);
        t_sample_item it;
        it.sample = s;
        it.last = l;
        pending_samples.push_back(it);
    endtask

    function automatic logic [31:0] random_sample(int style);
        case (style)
            0: return $urandom();
            1: return 32'($signed($urandom_range(16)) - 8);
            2: return 32'($signed($urandom_range(2000)) - 1000);
            default: return ($urandom_range(1)) ? 32'h7FFF_FFFF - $urandom_range(3)
                                                : 32'h8000_0000 + $urandom_range(3);
        endcase
    endfunction

    // A data set of random length, closed by last; sometimes cut short.
    task automatic queue_set();
        int len, style;
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 5) : $urandom_range(6, 30);
        style = $urandom_range(3);
        for (int i = 0; i < len; i++)
            queue_sample(($urandom_range(19) == 0) ? random_sample(3) : random_sample(style),
                         (i == len - 1) || ($urandom_range(99) == 0));
    endtask

    initial begin
        logic [p2qe_pkg::QL_W-1:0] levels[6];
        int per_phase;
        level_m = p2qe_pkg::QL_RESET;
        restart_set();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Set cut short before five samples: estimate stays zero.
        queue_sample(32'd5, 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b1);
        // Descending fill with the extremes, then samples equal to the extremes and inside.
        queue_sample(32'h7FFF_FFFF, 1'b0);
        queue_sample(32'd100, 1'b0);
        queue_sample(32'd0, 1'b0);
        queue_sample(32'hFFFF_FF00, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h8000_0000, 1'b0);
        queue_sample(32'h7FFF_FFFF, 1'b0);
        queue_sample(32'd50, 1'b0);
        queue_sample(32'd0, 1'b0);
        queue_sample(32'd1, 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b1);
        // Ties everywhere.
        for (int i = 0; i < 9; i++) queue_sample(32'd7, i == 8);
        drain();

        levels = '{16'd1, 16'd65535, p2qe_pkg::QL_RESET, 16'd0, 16'd0, 16'd0};
        for (int i = 3; i < 6; i++) levels[i] = $urandom_range(1, 65535);
        per_phase = 125;
        for (int ph = 0; ph < 6; ph++) begin
            write_level(levels[ph]);
            steady_flow = (ph == 2);
            while (pending_samples.size() < per_phase) queue_set();
            // The sender pauses here until every estimate is back.
            drain();
        end
        steady_flow = 1'b0;
        drain();
        repeat (50) @(posedge i_clk);
        if (error_count == 0) $display("Verification passed");
        else $display("Verification failed");
        $finish;
    end

endmodule

/* files.f */
src/p2qe_pkg.sv
src/p2qe_divider.sv
src/p2_quantile_estimator_core.sv
dv/p2_quantile_estimator_core_test.sv
